@@ rtl/core/dssm_pkg.sv @@
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types, codes and sizes for the dual stack shared memory block.
// ----------------------------------------------------------------------------
package dssm_pkg;

    // Memory size and derived widths
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Action codes
    localparam logic [2:0] ACT_PUSH_LO = 3'd0;
    localparam logic [2:0] ACT_PUSH_HI = 3'd1;
    localparam logic [2:0] ACT_POP_LO  = 3'd2;
    localparam logic [2:0] ACT_POP_HI  = 3'd3;
    localparam logic [2:0] ACT_DUMP_LO = 3'd4;
    localparam logic [2:0] ACT_DUMP_HI = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WAIT
    } state_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUSH_LO,
        OP_PUSH_HI,
        OP_POP_LO,
        OP_POP_HI,
        OP_DUMP_LO,
        OP_DUMP_HI,
        OP_STEP,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic low_empty;
        logic high_empty;
        logic full;
        logic low_one;
        logic high_one;
        logic walk_last;
    } dp_sts_t;

endpackage

@@ rtl/core/dssm_ctrl.sv @@
// ----------------------------------------------------------------------------
// dssm_ctrl
// Controller: decodes each accepted item into datapath operations and
// sequences the dump walk and the read wait.
// ----------------------------------------------------------------------------
module dssm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       action,
    input  dssm_pkg::dp_sts_t sts,
    output logic             busy,
    output dssm_pkg::cmd_t   cmd
);
    import dssm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_POP_LO:  if (!sts.low_empty)  state_next = S_WAIT;
                        ACT_POP_HI:  if (!sts.high_empty) state_next = S_WAIT;
                        ACT_DUMP_LO:
                        begin
                            if (!sts.low_empty)
                            begin
                                state_next = sts.low_one ? S_WAIT : S_WALK;
                            end
                        end
                        ACT_DUMP_HI:
                        begin
                            if (!sts.high_empty)
                            begin
                                state_next = sts.high_one ? S_WAIT : S_WALK;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_WALK:  if (sts.walk_last) state_next = S_WAIT;
            S_WAIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy       = 1'b1;
        cmd.op     = OP_NOP;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (action)
                        ACT_PUSH_LO, ACT_PUSH_HI:
                        begin
                            if (sts.full)
                            begin
                                cmd.op     = OP_REPORT;
                                cmd.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.op = (action == ACT_PUSH_LO) ? OP_PUSH_LO : OP_PUSH_HI;
                            end
                        end
                        ACT_POP_LO:
                        begin
                            cmd.op     = sts.low_empty ? OP_REPORT : OP_POP_LO;
                            cmd.status = sts.low_empty ? ST_UNDERFLOW : ST_OK;
                        end
                        ACT_POP_HI:
                        begin
                            cmd.op     = sts.high_empty ? OP_REPORT : OP_POP_HI;
                            cmd.status = sts.high_empty ? ST_UNDERFLOW : ST_OK;
                        end
                        ACT_DUMP_LO:
                        begin
                            cmd.op     = sts.low_empty ? OP_REPORT : OP_DUMP_LO;
                            cmd.status = sts.low_empty ? ST_EMPTY : ST_OK;
                        end
                        ACT_DUMP_HI:
                        begin
                            cmd.op     = sts.high_empty ? OP_REPORT : OP_DUMP_HI;
                            cmd.status = sts.high_empty ? ST_EMPTY : ST_OK;
                        end
                        default: cmd.op = OP_NOP;
                    endcase
                end
            end
            S_WALK:  cmd.op = OP_STEP;
            S_WAIT:  cmd.op = OP_NOP;
            default: cmd.op = OP_NOP;
        endcase
    end

endmodule

@@ rtl/core/dssm_dp.sv @@
// ----------------------------------------------------------------------------
// dssm_dp
// Datapath: stack counters, shared word memory with registered read,
// dump walk pointer and the result register.
// ----------------------------------------------------------------------------
module dssm_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  dssm_pkg::cmd_t    cmd,
    input  dssm_pkg::item_t   item,
    output dssm_pkg::dp_sts_t sts,
    output dssm_pkg::result_t result,
    output logic              strobe
);
    import dssm_pkg::*;

    logic signed [31:0] mem [DEPTH];

    logic [CNT_W-1:0]  low_cnt_reg,  low_cnt_next;
    logic [CNT_W-1:0]  high_cnt_reg, high_cnt_next;
    logic [ADDR_W-1:0] walk_ptr_reg, walk_ptr_next;
    logic              walk_up_reg,  walk_up_next;
    logic [CNT_W-1:0]  remain_reg,   remain_next;
    logic              rd_pend_reg,  rd_pend_next;
    logic              rd_last_reg,  rd_last_next;
    logic signed [31:0] rd_data_reg;
    result_t           result_reg,   result_next;
    logic              strobe_reg,   strobe_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W:0]    used_sum;

    // Status toward the controller
    assign used_sum       = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign sts.full       = used_sum >= {1'b0, DEPTH_C};
    assign sts.low_empty  = low_cnt_reg == '0;
    assign sts.high_empty = high_cnt_reg == '0;
    assign sts.low_one    = low_cnt_reg == CNT_W'(1);
    assign sts.high_one   = high_cnt_reg == CNT_W'(1);
    assign sts.walk_last  = remain_reg == CNT_W'(1);

    // Operation decode
    always_comb
    begin
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        walk_ptr_next = walk_ptr_reg;
        walk_up_next  = walk_up_reg;
        remain_next   = remain_reg;
        wr_en         = 1'b0;
        wr_addr       = low_cnt_reg[ADDR_W-1:0];
        rd_en         = 1'b0;
        rd_addr       = walk_ptr_reg;
        rd_last_next  = 1'b1;
        case (cmd.op)
            OP_PUSH_LO:
            begin
                wr_en        = 1'b1;
                wr_addr      = low_cnt_reg[ADDR_W-1:0];
                low_cnt_next = low_cnt_reg + CNT_W'(1);
            end
            OP_PUSH_HI:
            begin
                wr_en         = 1'b1;
                wr_addr       = ADDR_W'(DEPTH_C - CNT_W'(1) - high_cnt_reg);
                high_cnt_next = high_cnt_reg + CNT_W'(1);
            end
            OP_POP_LO:
            begin
                rd_en        = 1'b1;
                rd_addr      = ADDR_W'(low_cnt_reg - CNT_W'(1));
                low_cnt_next = low_cnt_reg - CNT_W'(1);
            end
            OP_POP_HI:
            begin
                rd_en         = 1'b1;
                rd_addr       = ADDR_W'(DEPTH_C - high_cnt_reg);
                high_cnt_next = high_cnt_reg - CNT_W'(1);
            end
            OP_DUMP_LO:
            begin
                // top of the low stack first, walking down to entry 0
                rd_en         = 1'b1;
                rd_addr       = ADDR_W'(low_cnt_reg - CNT_W'(1));
                walk_ptr_next = ADDR_W'(low_cnt_reg - CNT_W'(2));
                walk_up_next  = 1'b0;
                remain_next   = low_cnt_reg - CNT_W'(1);
                rd_last_next  = low_cnt_reg == CNT_W'(1);
            end
            OP_DUMP_HI:
            begin
                // top of the high stack first, walking up to the top entry
                rd_en         = 1'b1;
                rd_addr       = ADDR_W'(DEPTH_C - high_cnt_reg);
                walk_ptr_next = ADDR_W'(DEPTH_C - high_cnt_reg + CNT_W'(1));
                walk_up_next  = 1'b1;
                remain_next   = high_cnt_reg - CNT_W'(1);
                rd_last_next  = high_cnt_reg == CNT_W'(1);
            end
            OP_STEP:
            begin
                rd_en         = 1'b1;
                rd_addr       = walk_ptr_reg;
                walk_ptr_next = walk_up_reg ? walk_ptr_reg + ADDR_W'(1)
                                            : walk_ptr_reg - ADDR_W'(1);
                remain_next   = remain_reg - CNT_W'(1);
                rd_last_next  = remain_reg == CNT_W'(1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_pend_next = rd_en;

    // Result register: immediate reports, push acks and memory reads
    always_comb
    begin
        result_next = result_reg;
        strobe_next = 1'b0;
        if (rd_pend_reg)
        begin
            result_next.data   = rd_data_reg;
            result_next.status = ST_OK;
            result_next.last   = rd_last_reg;
            strobe_next        = 1'b1;
        end
        else if (cmd.op inside {OP_REPORT, OP_PUSH_LO, OP_PUSH_HI})
        begin
            result_next.data   = '0;
            result_next.status = (cmd.op == OP_REPORT) ? cmd.status : ST_OK;
            result_next.last   = 1'b1;
            strobe_next        = 1'b1;
        end
    end

    // Shared memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        walk_ptr_reg <= walk_ptr_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
            walk_up_reg  <= 1'b0;
            remain_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
            walk_up_reg  <= walk_up_next;
            remain_reg   <= remain_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            strobe_reg   <= strobe_next;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

`ifndef ASSERT_OFF
    // the two stacks never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        used_sum <= {1'b0, DEPTH_C})
        else $error("stack counters exceed memory depth");

    // every read issued produces a result transfer
    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> strobe_reg)
        else $error("read data was not emitted");

    // error reports are single, final results
    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_REPORT |=> strobe_reg && result_reg.last)
        else $error("status report not emitted as last result");

    // walk never steps past the base of a stack
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_STEP |-> remain_reg != '0)
        else $error("dump walk stepped past stack base");
`endif

endmodule

@@ rtl/core/dual_stack_shared_memory.sv @@
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two stacks in one word memory: low stack grows up from entry 0, high stack
// grows down from the top entry. Push, pop and dump on either stack.
// ----------------------------------------------------------------------------
// Timing: push acks and error reports are registered straight into the result
//   register; a pop reads its word into rd_data_reg, then into the result
//   register; a dump of n words goes the same way and emits one word a cycle.
// Throughput: one push or report per cycle; a pop or a dump holds busy through
//   its read wait, so no new item is taken before its last word is read.
// Reset: both stack counters clear, memory is not cleared; no receiver stall.
module dual_stack_shared_memory (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dssm_pkg::item_t   item,
    output logic              strobe,
    output dssm_pkg::result_t result
);
    import dssm_pkg::*;

    cmd_t    cmd;
    dp_sts_t sts;

    dssm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    dssm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .sts    (sts),
        .result (result),
        .strobe (strobe)
    );

endmodule
